FILE: rtl/bbia_pkg.sv
// Shared constants, types and helpers for the bitmap block/inode allocator.
`default_nettype none

package bbia_pkg;

    localparam int BITMAP_BYTES = 4096;
    localparam int NBITS        = BITMAP_BYTES * 8;
    localparam int NWORDS       = (BITMAP_BYTES + 3) / 4;

    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;
    localparam int ADDR_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int IDX_W    = ADDR_W + BIT_W;
    localparam int START_W  = 20;
    localparam int BLOCKS_W = 8;
    localparam int CMD_W    = 2;
    localparam int BLOCK_W  = 20;
    localparam int INODE_W  = 16;
    localparam int STATUS_W = 3;
    localparam int GRANT_W  = 20;
    localparam int LIMIT_W  = BLOCKS_W + $clog2(NBITS + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = START_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BLOCKS = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_FULL  = 3'd1;
    localparam status_t ST_BELOW = 3'd2;
    localparam status_t ST_RANGE = 3'd3;
    localparam status_t ST_FREE  = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC_DATA  = 2'd0,
        CMD_FREE_DATA   = 2'd1,
        CMD_ALLOC_INODE = 2'd2,
        CMD_FREE_INODE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [START_W-1:0]  blk_base;
        logic [BLOCKS_W-1:0] blk_maps;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] raddr;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              we_data;
        logic              we_inode;
    } ram_req_t;

    // Position of the lowest clear bit; zero when the word is all ones.
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!w[b]) idx = BIT_W'(b);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bbia_ram.sv
// Simple dual-port bitmap RAM with one write port and a registered read port.
`default_nettype none

module bbia_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/bbia_ctrl.sv
// Command sequencer: clear pass, bitmap scan, free check and result register.
`default_nettype none

module bbia_ctrl (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire bbia_pkg::cfg_t                    cfg,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [bbia_pkg::CMD_W-1:0]        s_cmd,
    input  wire logic [bbia_pkg::BLOCK_W-1:0]      s_block_num,
    input  wire logic [bbia_pkg::INODE_W-1:0]      s_inode_num,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output bbia_pkg::status_t                      m_status,
    output logic      [bbia_pkg::GRANT_W-1:0]      m_granted_number,
    output bbia_pkg::ram_req_t                     ram_req,
    input  wire logic [bbia_pkg::WORD_W-1:0]       rdata_data,
    input  wire logic [bbia_pkg::WORD_W-1:0]       rdata_inode
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE_RD,
        S_FREE_CHK,
        S_SCAN,
        S_DONE
    } state_t;

    localparam logic [bbia_pkg::ADDR_W-1:0] LAST_ADDR = bbia_pkg::ADDR_W'(bbia_pkg::NWORDS - 1);

    state_t                              state_reg;
    logic [bbia_pkg::ADDR_W-1:0]         clr_addr_reg;
    logic                                inode_reg;
    logic [bbia_pkg::IDX_W-1:0]          bit_idx_reg;
    logic [bbia_pkg::ADDR_W-1:0]         scan_addr_reg;
    logic                                scan_done_reg;
    logic [bbia_pkg::ADDR_W-1:0]         chk_addr_reg;
    logic                                chk_vld_reg;
    bbia_pkg::status_t                   res_status_reg;
    logic [bbia_pkg::GRANT_W-1:0]        res_grant_reg;
    logic                                m_valid_reg;
    bbia_pkg::status_t                   m_status_reg;
    logic [bbia_pkg::GRANT_W-1:0]        m_grant_reg;

    logic [bbia_pkg::WORD_W-1:0]         rdata_sel;
    logic                                found;
    logic [bbia_pkg::BIT_W-1:0]          lz;
    logic [bbia_pkg::IDX_W-1:0]          scan_idx;
    logic                                scan_over;
    logic [bbia_pkg::WORD_W-1:0]         free_mask;
    logic                                free_bit_set;
    logic                                data_below;
    logic [bbia_pkg::BLOCK_W-1:0]        data_off;
    logic [bbia_pkg::LIMIT_W-1:0]        data_limit;
    logic                                data_range;
    logic                                inode_range;
    logic [bbia_pkg::START_W-1:0]        data_grant;

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_granted_number = m_grant_reg;

    assign rdata_sel = inode_reg ? rdata_inode : rdata_data;

    // scan side: lowest clear bit of the word that just came back
    assign found     = ~&rdata_sel;
    assign lz        = bbia_pkg::lowest_zero(rdata_sel);
    assign scan_idx  = {chk_addr_reg, lz};
    assign scan_over = ({1'b0, scan_idx} >= (bbia_pkg::IDX_W + 1)'(bbia_pkg::NBITS));

    // free side
    assign free_mask    = bbia_pkg::WORD_W'(1) << bit_idx_reg[bbia_pkg::BIT_W-1:0];
    assign free_bit_set = |(rdata_sel & free_mask);

    // range checks on the incoming word
    assign data_below  = (s_block_num < cfg.blk_base);
    assign data_off    = s_block_num - cfg.blk_base;
    assign data_limit  = bbia_pkg::LIMIT_W'(cfg.blk_maps) * bbia_pkg::LIMIT_W'(bbia_pkg::NBITS);
    assign data_range  = (bbia_pkg::LIMIT_W'(data_off) >= data_limit) ||
                         (bbia_pkg::LIMIT_W'(data_off) >= bbia_pkg::LIMIT_W'(bbia_pkg::NBITS));
    assign inode_range = (bbia_pkg::LIMIT_W'(s_inode_num) >= bbia_pkg::LIMIT_W'(bbia_pkg::NBITS));

    assign data_grant = cfg.blk_base + bbia_pkg::START_W'(scan_idx);

    always_comb begin
        ram_req          = '0;
        ram_req.raddr    = (state_reg == S_SCAN) ? scan_addr_reg
                                                 : bit_idx_reg[bbia_pkg::IDX_W-1:bbia_pkg::BIT_W];
        unique case (state_reg)
            S_CLEAR: begin
                ram_req.waddr    = clr_addr_reg;
                ram_req.wdata    = '0;
                ram_req.we_data  = 1'b1;
                ram_req.we_inode = 1'b1;
            end
            S_FREE_CHK: begin
                ram_req.waddr    = bit_idx_reg[bbia_pkg::IDX_W-1:bbia_pkg::BIT_W];
                ram_req.wdata    = rdata_sel & ~free_mask;
                ram_req.we_data  = free_bit_set && !inode_reg;
                ram_req.we_inode = free_bit_set && inode_reg;
            end
            S_SCAN: begin
                ram_req.waddr    = chk_addr_reg;
                ram_req.wdata    = rdata_sel | (bbia_pkg::WORD_W'(1) << lz);
                ram_req.we_data  = chk_vld_reg && found && !scan_over && !inode_reg;
                ram_req.we_inode = chk_vld_reg && found && !scan_over && inode_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            chk_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_ADDR) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        inode_reg     <= s_cmd[1];
                        res_grant_reg <= '0;
                        scan_addr_reg <= '0;
                        scan_done_reg <= 1'b0;
                        chk_vld_reg   <= 1'b0;
                        unique case (bbia_pkg::cmd_t'(s_cmd))
                            bbia_pkg::CMD_ALLOC_DATA,
                            bbia_pkg::CMD_ALLOC_INODE: begin
                                state_reg <= S_SCAN;
                            end
                            bbia_pkg::CMD_FREE_DATA: begin
                                bit_idx_reg <= bbia_pkg::IDX_W'(data_off);
                                if (data_below) begin
                                    res_status_reg <= bbia_pkg::ST_BELOW;
                                    state_reg      <= S_DONE;
                                end else if (data_range) begin
                                    res_status_reg <= bbia_pkg::ST_RANGE;
                                    state_reg      <= S_DONE;
                                end else begin
                                    state_reg <= S_FREE_RD;
                                end
                            end
                            bbia_pkg::CMD_FREE_INODE: begin
                                bit_idx_reg <= bbia_pkg::IDX_W'(s_inode_num);
                                if (inode_range) begin
                                    res_status_reg <= bbia_pkg::ST_RANGE;
                                    state_reg      <= S_DONE;
                                end else begin
                                    state_reg <= S_FREE_RD;
                                end
                            end
                        endcase
                    end
                end
                S_FREE_RD: begin
                    state_reg <= S_FREE_CHK;
                end
                S_FREE_CHK: begin
                    res_status_reg <= free_bit_set ? bbia_pkg::ST_OK : bbia_pkg::ST_FREE;
                    state_reg      <= S_DONE;
                end
                S_SCAN: begin
                    // one read issued per cycle, checked in the cycle after
                    if (!scan_done_reg) begin
                        chk_addr_reg  <= scan_addr_reg;
                        chk_vld_reg   <= 1'b1;
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                        if (scan_addr_reg == LAST_ADDR) begin
                            scan_done_reg <= 1'b1;
                        end
                    end else begin
                        chk_vld_reg <= 1'b0;
                    end
                    if (chk_vld_reg) begin
                        if (found) begin
                            state_reg   <= S_DONE;
                            chk_vld_reg <= 1'b0;
                            if (scan_over) begin
                                res_status_reg <= bbia_pkg::ST_FULL;
                            end else begin
                                res_status_reg <= bbia_pkg::ST_OK;
                                res_grant_reg  <= inode_reg
                                    ? bbia_pkg::GRANT_W'(bbia_pkg::INODE_W'(scan_idx))
                                    : bbia_pkg::GRANT_W'(data_grant);
                            end
                        end else if (chk_addr_reg == LAST_ADDR) begin
                            state_reg      <= S_DONE;
                            chk_vld_reg    <= 1'b0;
                            res_status_reg <= bbia_pkg::ST_FULL;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_grant_reg  <= res_grant_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bitmap_block_inode_allocator.sv
// Top level of the bitmap block/inode allocator: config registers, sequencer, bitmap RAMs.
//
//  Channel   Ports                                         Direction
//  input     s_valid/s_ready, s_cmd, s_block_num,          in
//            s_inode_num
//  result    m_valid/m_ready, m_status, m_granted_number   out
//  config    cfg_wr_en, cfg_index, cfg_data                in
//
//  One command at a time. A free reads the bitmap word, checks the bit and
//  clears it if set, then registers its result; a free that its range check
//  rejects goes straight to the result register. An allocate scans the bitmap
//  one word per cycle from word 0 until it finds a clear bit or the last word.
//  After reset both bitmaps are zeroed; s_ready stays low during that pass.
//  A result waits in the output register while m_ready is low; the next word
//  can be accepted meanwhile but finishes behind it.
`default_nettype none

module bitmap_block_inode_allocator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [bbia_pkg::CMD_W-1:0]          s_cmd,
    input  wire logic [bbia_pkg::BLOCK_W-1:0]        s_block_num,
    input  wire logic [bbia_pkg::INODE_W-1:0]        s_inode_num,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [bbia_pkg::STATUS_W-1:0]       m_status,
    output logic      [bbia_pkg::GRANT_W-1:0]        m_granted_number,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bbia_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bbia_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bbia_pkg::cfg_t               cfg_reg;
    bbia_pkg::ram_req_t           ram_req;
    logic [bbia_pkg::WORD_W-1:0]  rdata_data;
    logic [bbia_pkg::WORD_W-1:0]  rdata_inode;
    bbia_pkg::status_t            status_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blk_base <= '0;
            cfg_reg.blk_maps <= bbia_pkg::BLOCKS_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bbia_pkg::CFG_DATA_START:  cfg_reg.blk_base <= cfg_data;
                bbia_pkg::CFG_DATA_BLOCKS: cfg_reg.blk_maps <= cfg_data[bbia_pkg::BLOCKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bbia_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_block_num      (s_block_num),
        .s_inode_num      (s_inode_num),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (status_w),
        .m_granted_number (m_granted_number),
        .ram_req          (ram_req),
        .rdata_data       (rdata_data),
        .rdata_inode      (rdata_inode)
    );

    assign m_status = status_w;

    bbia_ram #(
        .DEPTH (bbia_pkg::NWORDS),
        .WIDTH (bbia_pkg::WORD_W)
    ) u_data_map (
        .aclk  (aclk),
        .we    (ram_req.we_data),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (rdata_data)
    );

    bbia_ram #(
        .DEPTH (bbia_pkg::NWORDS),
        .WIDTH (bbia_pkg::WORD_W)
    ) u_inode_map (
        .aclk  (aclk),
        .we    (ram_req.we_inode),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (rdata_inode)
    );

endmodule

`default_nettype wire

FILE: rtl/bbia_checker.sv
// Port-level assertions for the allocator, bound to the top level.
`default_nettype none

module bbia_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic [bbia_pkg::STATUS_W-1:0]       m_status,
    input wire logic [bbia_pkg::GRANT_W-1:0]        m_granted_number
);

    // the clearing pass holds off input right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high in the cycle after reset");

    // one command in flight: never ready right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted back to back");

    // errors never carry a number; an OK free is not covered by this check
    a_err_zero_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != bbia_pkg::ST_OK) |-> (m_granted_number == '0))
        else $error("nonzero granted number on error status");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_granted_number))
        else $error("result word changed while stalled");

endmodule

bind bitmap_block_inode_allocator bbia_checker u_bbia_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_granted_number (m_granted_number)
);

`default_nettype wire
